/* rtl/json_string_unescape_to_utf8_macros.svh */
// ----------------------------------------------------------------------------
// JSON string unescaper assertion macros
// Concurrent checks on a clock with an active-low reset; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_TO_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_TO_UTF8_MACROS_SVH

`ifndef SYNTHESIS
`define JSU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jsu check failed");
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jsu check failed");
`else
`define JSU_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/jsu_pkg.sv */
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and helpers of the JSON string unescaper.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

    localparam int MaxResults = 4;

    localparam logic [1:0] STATUS_BYTE = 2'd0;
    localparam logic [1:0] STATUS_OK   = 2'd1;
    localparam logic [1:0] STATUS_ERR  = 2'd2;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    typedef enum logic [2:0] {
        MODE_PLAIN  = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_HEX1   = 3'd2,
        MODE_LOW_BS = 3'd3,
        MODE_LOW_U  = 3'd4,
        MODE_HEX2   = 3'd5
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        logic [1:0]  digit_count;
        logic [15:0] hex_accum;
        logic [9:0]  high_bits;
    } dec_state_t;

    typedef struct packed {
        logic [2:0]            count;
        logic [1:0]            status;
        logic [3:0][7:0]       bytes;
    } dec_result_t;

    // Bit 4 set flags a byte that is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c inside {[8'h30:8'h39]})
            v = 5'(c - 8'h30);
        else if (c inside {[8'h61:8'h66]})
            v = 5'(c - 8'h57);
        else if (c inside {[8'h41:8'h46]})
            v = 5'(c - 8'h37);
        return v;
    endfunction

endpackage

`default_nettype wire

/* rtl/jsu_if.sv */
// ----------------------------------------------------------------------------
// jsu_in_if / jsu_out_if
// Valid/ready channels for raw string bytes and decoded results.
// ----------------------------------------------------------------------------
`default_nettype none

interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       end_of_text;

    modport source (output valid, output byte_value, output end_of_text, input ready);
    modport sink   (input valid, input byte_value, input end_of_text, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic [1:0] status;
    logic       last_of_run;

    modport source (output valid, output byte_out, output status, output last_of_run,
                    input ready);
    modport sink   (input valid, input byte_out, input status, input last_of_run,
                    output ready);
endinterface

`default_nettype wire

/* rtl/jsu_decode.sv */
// ----------------------------------------------------------------------------
// jsu_decode
// Per-byte decode step: next decoder state and up to four result bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_decode (
    input  jsu_pkg::dec_state_t  state,
    input  logic [7:0]           byte_value,
    input  logic                 end_of_text,
    output jsu_pkg::dec_state_t  state_next,
    output jsu_pkg::dec_result_t result
);
    import jsu_pkg::*;

    function automatic dec_result_t one_byte(input logic [7:0] b);
        dec_result_t r;
        r = '0;
        r.count    = 3'd1;
        r.status   = STATUS_BYTE;
        r.bytes[0] = b;
        return r;
    endfunction

    function automatic dec_result_t utf8(input logic [20:0] cp);
        dec_result_t r;
        r = '0;
        r.status = STATUS_BYTE;
        if (cp <= 21'h7F) begin
            r.count    = 3'd1;
            r.bytes[0] = cp[7:0];
        end
        else if (cp <= 21'h7FF) begin
            r.count    = 3'd2;
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
        end
        else if (cp <= 21'hFFFF) begin
            r.count    = 3'd3;
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
        end
        else begin
            r.count    = 3'd4;
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

    logic [4:0]  hv;
    logic [15:0] acc;
    logic        err;
    logic [20:0] pair_cp;

    assign hv      = hex_value(byte_value);
    assign acc     = {state.hex_accum[11:0], hv[3:0]};
    assign pair_cp = 21'h10000 + {1'b0, state.high_bits, acc[9:0]};

    always_comb
    begin
        state_next = state;
        result     = '0;
        err        = 1'b0;
        if (end_of_text)
        begin
            err = 1'b1;
        end
        else
        begin
            case (state.mode)
                MODE_ESC:
                begin
                    state_next.mode = MODE_PLAIN;
                    case (byte_value)
                        CH_QUOTE, CH_BACKSLASH, CH_SLASH: result = one_byte(byte_value);
                        CH_B: result = one_byte(8'h08);
                        CH_F: result = one_byte(8'h0C);
                        CH_N: result = one_byte(8'h0A);
                        CH_R: result = one_byte(8'h0D);
                        CH_T: result = one_byte(8'h09);
                        CH_U:
                        begin
                            state_next.mode        = MODE_HEX1;
                            state_next.digit_count = 2'd0;
                            state_next.hex_accum   = '0;
                        end
                        default: err = 1'b1;
                    endcase
                end
                MODE_HEX1, MODE_HEX2:
                begin
                    if (hv[4])
                    begin
                        err = 1'b1;
                    end
                    else if (state.digit_count != 2'd3)
                    begin
                        state_next.hex_accum   = acc;
                        state_next.digit_count = state.digit_count + 2'd1;
                    end
                    else if (state.mode == MODE_HEX1)
                    begin
                        // High surrogate waits for its partner; low one alone fails.
                        if (acc[15:10] == 6'b110110)
                        begin
                            state_next.mode        = MODE_LOW_BS;
                            state_next.digit_count = 2'd0;
                            state_next.hex_accum   = '0;
                            state_next.high_bits   = acc[9:0];
                        end
                        else if (acc[15:10] == 6'b110111)
                        begin
                            err = 1'b1;
                        end
                        else
                        begin
                            state_next = '0;
                            result     = utf8({5'd0, acc});
                        end
                    end
                    else
                    begin
                        if (acc[15:10] != 6'b110111)
                        begin
                            err = 1'b1;
                        end
                        else
                        begin
                            state_next = '0;
                            result     = utf8(pair_cp);
                        end
                    end
                end
                MODE_LOW_BS:
                begin
                    if (byte_value != CH_BACKSLASH)
                        err = 1'b1;
                    else
                        state_next.mode = MODE_LOW_U;
                end
                MODE_LOW_U:
                begin
                    if (byte_value != CH_U)
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        state_next.mode        = MODE_HEX2;
                        state_next.digit_count = 2'd0;
                        state_next.hex_accum   = '0;
                    end
                end
                default:
                begin
                    state_next.mode = MODE_PLAIN;
                    if (byte_value == CH_QUOTE)
                    begin
                        state_next    = '0;
                        result.count  = 3'd1;
                        result.status = STATUS_OK;
                    end
                    else if (byte_value == CH_BACKSLASH)
                    begin
                        state_next.mode = MODE_ESC;
                    end
                    else if (byte_value < CH_SPACE)
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        result = one_byte(byte_value);
                    end
                end
            endcase
        end
        if (err)
        begin
            state_next    = '0;
            result        = '0;
            result.count  = 3'd1;
            result.status = STATUS_ERR;
        end
    end

endmodule

`default_nettype wire

/* rtl/json_string_unescape_to_utf8.sv */
// ----------------------------------------------------------------------------
// json_string_unescape_to_utf8
// JSON string body unescaper with UTF-8 output.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one raw byte of a string body per word, starting after the
//   opening quote; end_of_text marks that the text ran out. out_ch carries
//   decoded UTF-8 bytes (status 0), then one word with status 1 at the
//   closing quote or status 2 on any error; last_of_run marks the final word
//   caused by one input byte. After status 1 or 2 the next byte starts a new
//   string body.
//   An accepted byte is held in the input register and decoded into the
//   result buffer once that is free; out_ch is driven from the buffer.
//   Throughput: one input word per cycle while out_ch is ready and each
//   byte gives at most one result. A completed \u escape gives 1 to 4 bytes,
//   drained one per cycle from the result buffer while out_ch is ready;
//   the next byte waits in the input register until the last is taken.
//   Reset clears the decoder to plain mode and empties both registers.
//   A stall on out_ch holds the buffered results; input backs up once the
//   input register is also full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "json_string_unescape_to_utf8_macros.svh"

module json_string_unescape_to_utf8 (
    input  logic            clk,
    input  logic            rst_n,
    jsu_in_if.sink          in_ch,
    jsu_out_if.source       out_ch
);
    import jsu_pkg::*;

    logic                     s1_valid_reg;
    logic [7:0]               s1_byte_reg;
    logic                     s1_eot_reg;
    dec_state_t               state_reg;
    dec_state_t               state_next;
    dec_result_t              result;
    logic [2:0]               rem_reg;
    logic [2:0]               rem_next;
    logic [1:0]               status_reg;
    logic [MaxResults-1:0][7:0] bytes_reg;

    logic s2_free;
    logic s1_move;
    logic pop;

    jsu_decode u_decode (
        .state       (state_reg),
        .byte_value  (s1_byte_reg),
        .end_of_text (s1_eot_reg),
        .state_next  (state_next),
        .result      (result)
    );

    assign pop          = out_ch.valid && out_ch.ready;
    assign s2_free      = (rem_reg == 3'd0) || ((rem_reg == 3'd1) && out_ch.ready);
    assign s1_move      = s1_valid_reg && s2_free;
    assign in_ch.ready  = !s1_valid_reg || s1_move;

    assign out_ch.valid       = (rem_reg != 3'd0);
    assign out_ch.byte_out    = bytes_reg[0];
    assign out_ch.status      = status_reg;
    assign out_ch.last_of_run = (rem_reg == 3'd1);

    always_comb
    begin
        rem_next = rem_reg;
        if (s1_move)
            rem_next = result.count;
        else if (pop)
            rem_next = rem_reg - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            rem_reg      <= '0;
            state_reg    <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
            if (in_ch.ready)
                s1_valid_reg <= in_ch.valid;
            if (s1_move)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_byte_reg <= in_ch.byte_value;
            s1_eot_reg  <= in_ch.end_of_text;
        end
        if (s1_move)
        begin
            bytes_reg  <= result.bytes;
            status_reg <= result.status;
        end
        else if (pop)
        begin
            // advance to the next buffered byte
            bytes_reg <= {8'h00, bytes_reg[MaxResults-1:1]};
        end
    end

    `JSU_ASSERT_IMPL(a_final_status_last, clk, rst_n,
        out_ch.valid && out_ch.status != STATUS_BYTE, out_ch.last_of_run)
    `JSU_ASSERT_NEXT(a_err_resets_mode, clk, rst_n,
        s1_move && result.status == STATUS_ERR && result.count != 3'd0,
        state_reg.mode == MODE_PLAIN && state_reg.hex_accum == 16'd0)
    `JSU_ASSERT_NEXT(a_eot_clears_state, clk, rst_n,
        s1_move && s1_eot_reg, state_reg == '0 && rem_reg == 3'd1)
    `JSU_ASSERT_NEXT(a_drain_empties, clk, rst_n,
        pop && out_ch.last_of_run && !s1_move, !out_ch.valid)

endmodule

`default_nettype wire

/* dv/tb_json_string_unescape_to_utf8.sv */
// ----------------------------------------------------------------------------
// tb_json_string_unescape_to_utf8
// Drives string body bytes through the unescaper and checks every decoded
// word against a cycle-free decoder kept in the bench, with random idling,
// a long output stall and a burst with no idling on either side.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_json_string_unescape_to_utf8;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    typedef struct packed {
        logic [7:0] byte_out;
        logic [1:0] status;
        logic       last_of_run;
    } out_word_t;

    logic clk;
    logic rst_n;

    jsu_in_if  in_ch ();
    jsu_out_if out_ch ();

    json_string_unescape_to_utf8 uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // decoder state mirrored in the bench
    mode_t       dec_mode;
    logic [1:0]  dec_digits;
    logic [15:0] dec_accum;
    logic [9:0]  dec_high;

    out_word_t decoded_q[$];
    int        fail_count = 0;
    int        sent_words = 0;
    bit        src_idle   = 1'b1;
    bit        sink_idle  = 1'b1;
    int        stall_len  = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Decoder
    // ------------------------------------------------------------------
    function automatic void clear_decoder();
        dec_mode   = MODE_PLAIN;
        dec_digits = 2'd0;
        dec_accum  = 16'h0000;
        dec_high   = 10'd0;
    endfunction

    function automatic void add_word(input logic [7:0] b, input logic [1:0] st);
        out_word_t w;
        w.byte_out    = b;
        w.status      = st;
        w.last_of_run = 1'b0;
        decoded_q = {decoded_q, w};
    endfunction

    function automatic void add_error();
        clear_decoder();
        add_word(8'h00, STATUS_ERR);
    endfunction

    // Bit 4 flags a non-hex byte.
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return {1'b0, 4'(c - 8'h30)};
        if (c >= 8'h61 && c <= 8'h66)
            return {1'b0, 4'(c - 8'h61 + 8'd10)};
        if (c >= 8'h41 && c <= 8'h46)
            return {1'b0, 4'(c - 8'h41 + 8'd10)};
        return 5'h10;
    endfunction

    function automatic void add_utf8(input logic [20:0] cp);
        if (cp <= 21'h7F)
            add_word(cp[7:0], STATUS_BYTE);
        else if (cp <= 21'h7FF)
        begin
            add_word({3'b110, cp[10:6]}, STATUS_BYTE);
            add_word({2'b10, cp[5:0]}, STATUS_BYTE);
        end
        else if (cp <= 21'hFFFF)
        begin
            add_word({4'b1110, cp[15:12]}, STATUS_BYTE);
            add_word({2'b10, cp[11:6]}, STATUS_BYTE);
            add_word({2'b10, cp[5:0]}, STATUS_BYTE);
        end
        else
        begin
            add_word({5'b11110, cp[20:18]}, STATUS_BYTE);
            add_word({2'b10, cp[17:12]}, STATUS_BYTE);
            add_word({2'b10, cp[11:6]}, STATUS_BYTE);
            add_word({2'b10, cp[5:0]}, STATUS_BYTE);
        end
    endfunction

    function automatic void unescape_step(input logic [7:0] c, input logic eot);
        int          n_before;
        logic [4:0]  d;
        logic [15:0] unit;
        logic [20:0] cp;
        n_before = decoded_q.size();
        if (eot)
            add_error();
        else
        begin
            case (dec_mode)
                MODE_ESC:
                begin
                    dec_mode = MODE_PLAIN;
                    case (c)
                        CH_QUOTE, CH_BACKSLASH, CH_SLASH: add_word(c, STATUS_BYTE);
                        CH_B: add_word(8'h08, STATUS_BYTE);
                        CH_F: add_word(8'h0C, STATUS_BYTE);
                        CH_N: add_word(8'h0A, STATUS_BYTE);
                        CH_R: add_word(8'h0D, STATUS_BYTE);
                        CH_T: add_word(8'h09, STATUS_BYTE);
                        CH_U:
                        begin
                            dec_mode   = MODE_HEX1;
                            dec_digits = 2'd0;
                            dec_accum  = 16'h0000;
                        end
                        default: add_error();
                    endcase
                end
                MODE_HEX1, MODE_HEX2:
                begin
                    d = hex_nibble(c);
                    if (d[4])
                        add_error();
                    else
                    begin
                        dec_accum = {dec_accum[11:0], d[3:0]};
                        if (dec_digits != 2'd3)
                            dec_digits = dec_digits + 2'd1;
                        else
                        begin
                            dec_digits = 2'd0;
                            unit = dec_accum;
                            if (dec_mode == MODE_HEX1)
                            begin
                                if (unit >= 16'hD800 && unit <= 16'hDBFF)
                                begin
                                    // hold the high half until its partner arrives
                                    dec_high  = unit[9:0];
                                    dec_accum = 16'h0000;
                                    dec_mode  = MODE_LOW_BS;
                                end
                                else if (unit >= 16'hDC00 && unit <= 16'hDFFF)
                                    add_error();
                                else
                                begin
                                    clear_decoder();
                                    add_utf8({5'd0, unit});
                                end
                            end
                            else if (unit < 16'hDC00 || unit > 16'hDFFF)
                                add_error();
                            else
                            begin
                                cp = 21'h10000 + {1'b0, dec_high, 10'd0} + {11'd0, unit[9:0]};
                                clear_decoder();
                                add_utf8(cp);
                            end
                        end
                    end
                end
                MODE_LOW_BS:
                begin
                    if (c != CH_BACKSLASH)
                        add_error();
                    else
                        dec_mode = MODE_LOW_U;
                end
                MODE_LOW_U:
                begin
                    if (c != CH_U)
                        add_error();
                    else
                    begin
                        dec_mode   = MODE_HEX2;
                        dec_digits = 2'd0;
                        dec_accum  = 16'h0000;
                    end
                end
                default:
                begin
                    dec_mode = MODE_PLAIN;
                    if (c == CH_QUOTE)
                    begin
                        clear_decoder();
                        add_word(8'h00, STATUS_OK);
                    end
                    else if (c == CH_BACKSLASH)
                        dec_mode = MODE_ESC;
                    else if (c < CH_SPACE)
                        add_error();
                    else
                        add_word(c, STATUS_BYTE);
                end
            endcase
        end
        if (decoded_q.size() > n_before)
            decoded_q[$].last_of_run = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        out_word_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (decoded_q.size() == 0)
            begin
                $error("unexpected word: byte_out %h status %0d last_of_run %0d",
                       out_ch.byte_out, out_ch.status, out_ch.last_of_run);
                fail_count++;
            end
            else
            begin
                want = decoded_q.pop_front();
                if (out_ch.byte_out !== want.byte_out)
                begin
                    $error("byte_out mismatch: expected %h, got %h",
                           want.byte_out, out_ch.byte_out);
                    fail_count++;
                end
                if (out_ch.status !== want.status)
                begin
                    $error("status mismatch: expected %0d, got %0d",
                           want.status, out_ch.status);
                    fail_count++;
                end
                if (out_ch.last_of_run !== want.last_of_run)
                begin
                    $error("last_of_run mismatch: expected %0d, got %0d",
                           want.last_of_run, out_ch.last_of_run);
                    fail_count++;
                end
            end
        end
    end

    // Output ready: random idling, or a counted hold-off when one is requested.
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_len > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall_len) @(posedge clk);
                stall_len = 0;
            end
            else
                out_ch.ready <= !(sink_idle && $urandom_range(0, 99) < 29);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_word(input logic [7:0] b, input logic eot);
        if (src_idle && $urandom_range(0, 99) < 29)
        begin
            in_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < 29);
        end
        in_ch.valid       <= 1'b1;
        in_ch.byte_value  <= b;
        in_ch.end_of_text <= eot;
        do @(posedge clk); while (!in_ch.ready);
        unescape_step(b, eot);
        sent_words++;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + 8'(n);
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    task automatic send_unicode(input logic [15:0] unit);
        send_word(CH_BACKSLASH, 1'b0);
        send_word(CH_U, 1'b0);
        send_word(hex_char(unit[15:12]), 1'b0);
        send_word(hex_char(unit[11:8]), 1'b0);
        send_word(hex_char(unit[7:4]), 1'b0);
        send_word(hex_char(unit[3:0]), 1'b0);
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(8'h20, 8'hFF));
        while (c == CH_QUOTE || c == CH_BACKSLASH);
        return c;
    endfunction

    function automatic logic [7:0] escape_letter();
        case ($urandom_range(0, 7))
            0: return CH_QUOTE;
            1: return CH_BACKSLASH;
            2: return CH_SLASH;
            3: return CH_B;
            4: return CH_F;
            5: return CH_N;
            6: return CH_R;
            default: return CH_T;
        endcase
    endfunction

    function automatic bit is_escape_letter(input logic [7:0] c);
        return c == CH_QUOTE || c == CH_BACKSLASH || c == CH_SLASH || c == CH_B ||
               c == CH_F || c == CH_N || c == CH_R || c == CH_T || c == CH_U;
    endfunction

    // Non-surrogate unit, spread over the 1, 2 and 3 byte encodings.
    function automatic logic [15:0] bmp_unit();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(16'h0000, 16'h007F));
            1: return 16'($urandom_range(16'h0080, 16'h07FF));
            2: return 16'($urandom_range(16'h0800, 16'hD7FF));
            default: return 16'($urandom_range(16'hE000, 16'hFFFF));
        endcase
    endfunction

    function automatic logic [15:0] high_unit();
        return 16'hD800 | 16'($urandom_range(0, 1023));
    endfunction

    function automatic logic [15:0] low_unit();
        return 16'hDC00 | 16'($urandom_range(0, 1023));
    endfunction

    task automatic send_broken();
        logic [7:0]  c;
        logic [15:0] unit;
        logic [4:0]  nib;
        int          k;
        case ($urandom_range(0, 7))
            0: send_word(8'($urandom_range(0, 31)), 1'b0);
            1:
            begin
                do c = 8'($urandom_range(0, 255)); while (is_escape_letter(c));
                send_word(CH_BACKSLASH, 1'b0);
                send_word(c, 1'b0);
            end
            2:
            begin
                unit = 16'($urandom);
                send_word(CH_BACKSLASH, 1'b0);
                send_word(CH_U, 1'b0);
                k = $urandom_range(0, 3);
                for (int i = 0; i < k; i++)
                    send_word(hex_char(unit[4*i +: 4]), 1'b0);
                do
                begin
                    c   = 8'($urandom_range(0, 255));
                    nib = hex_nibble(c);
                end
                while (!nib[4]);
                send_word(c, 1'b0);
            end
            3: send_unicode(low_unit());
            4:
            begin
                send_unicode(high_unit());
                if ($urandom_range(0, 1))
                begin
                    do c = 8'($urandom_range(0, 255)); while (c == CH_BACKSLASH);
                    send_word(c, 1'b0);
                end
                else
                begin
                    do c = 8'($urandom_range(0, 255)); while (c == CH_U);
                    send_word(CH_BACKSLASH, 1'b0);
                    send_word(c, 1'b0);
                end
            end
            5:
            begin
                send_unicode(high_unit());
                send_unicode($urandom_range(0, 3) == 0 ? high_unit() : bmp_unit());
            end
            6:
            begin
                // cut the text inside a surrogate pair at a random point
                unit = high_unit();
                k = $urandom_range(0, 9);
                if (k > 0) send_word(CH_BACKSLASH, 1'b0);
                if (k > 1) send_word(CH_U, 1'b0);
                for (int i = 2; i < k && i < 6; i++)
                    send_word(hex_char(unit[4*(5-i) +: 4]), 1'b0);
                if (k > 6) send_word(CH_BACKSLASH, 1'b0);
                if (k > 7) send_word(CH_U, 1'b0);
                if (k > 8) send_word(hex_char(4'hD), 1'b0);
                send_word(8'($urandom_range(0, 255)), 1'b1);
            end
            default: send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        endcase
    endtask

    task automatic send_token(input bit with_noise);
        int pick;
        pick = with_noise ? $urandom_range(0, 99) : $urandom_range(0, 82);
        if (pick < 35)
            send_word(plain_char(), 1'b0);
        else if (pick < 50)
        begin
            send_word(CH_BACKSLASH, 1'b0);
            send_word(escape_letter(), 1'b0);
        end
        else if (pick < 65)
            send_unicode(bmp_unit());
        else if (pick < 75)
        begin
            send_unicode(high_unit());
            send_unicode(low_unit());
        end
        else if (pick < 83)
            send_word(CH_QUOTE, 1'b0);
        else
            send_broken();
    endtask

    // Stop offering and let every expected word come out.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        send_word(CH_SPACE, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h1F, 1'b0);
        send_word(CH_QUOTE, 1'b0);
        send_word(CH_BACKSLASH, 1'b0);
        send_word(CH_SLASH, 1'b0);
        send_word(CH_BACKSLASH, 1'b0);
        send_word(8'h78, 1'b0);
        send_unicode(16'hD83D);
        send_unicode(16'hDE00);
        send_unicode(16'hDC00);
        send_word(8'h00, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_strings(input int n);
        int stop_at;
        stop_at = sent_words + n;
        while (sent_words < stop_at)
            send_token(1'b1);
        wait_drained();
    endtask

    task automatic test_back_to_back(input int n);
        int stop_at;
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        stop_at   = sent_words + n;
        while (sent_words < stop_at)
            send_token(1'b0);
        wait_drained();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    task automatic test_output_stall(input int n);
        int stop_at;
        src_idle  = 1'b0;
        stall_len = 40;
        stop_at   = sent_words + n;
        while (sent_words < stop_at)
            send_token(1'b1);
        src_idle = 1'b1;
        wait_drained();
    endtask

    initial
    begin
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.byte_value  = 8'h00;
        in_ch.end_of_text = 1'b0;
        clear_decoder();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_strings(110);
        test_back_to_back(60);
        test_output_stall(30);

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
+incdir+rtl
rtl/jsu_pkg.sv
rtl/jsu_if.sv
rtl/jsu_decode.sv
rtl/json_string_unescape_to_utf8.sv
dv/tb_json_string_unescape_to_utf8.sv
